/* rtl/aadw_pkg.sv */
// Shared types and constants for the area-average downsampler.
// Depends on nothing; every rtl module uses it by scoped names.
package aadw_pkg;

	localparam int COORD_W    = 12;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int GRAY_W     = 8;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_SRC_SIZE = 2'd0;
	localparam reg_idx_t REG_WIN_LOW  = 2'd1;
	localparam reg_idx_t REG_WIN_HIGH = 2'd2;

	localparam logic [GRAY_W-1:0] GRAY_MAX = 8'd255;

	// one classified source sample on its way from front to back
	typedef struct packed {
		logic signed [31:0]  sample;
		logic                finite;
		logic                first;
		logic                last;
		logic                frame_done;
		logic [COORD_W-1:0]  col;
		logic [COORD_W-1:0]  row;
	} item_t;

	typedef enum logic [1:0] {
		F_INIT,
		F_DIV,
		F_RUN
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_ACC,
		B_MUL,
		B_CMP,
		B_DIV,
		B_OUT
	} back_state_t;

endpackage

/* rtl/aadw_fifo.sv */
// Short item queue between the front and back sections.
// Depends on aadw_pkg (item_t, depth constants).
module aadw_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  aadw_pkg::item_t item_in,
	output logic          full,
	input  logic          pop,
	output aadw_pkg::item_t item_out,
	output logic          empty
);

	aadw_pkg::item_t               slot_q [aadw_pkg::FIFO_DEPTH];
	logic [aadw_pkg::FIFO_AW-1:0]  wptr_q;
	logic [aadw_pkg::FIFO_AW-1:0]  rptr_q;
	logic [aadw_pkg::FIFO_AW:0]    count_q;
	logic                          do_push;
	logic                          do_pop;

	assign full     = count_q == (aadw_pkg::FIFO_AW+1)'(aadw_pkg::FIFO_DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign item_out = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + 1'b1;
			if (do_pop) rptr_q <= rptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wptr_q] <= item_in;
	end

endmodule

/* rtl/aadw_front.sv */
// Front section: tracks the source position and the bin edges, tags each item
// with its bin, first/last flags and frame end. Depends on aadw_pkg.
module aadw_front #(
	parameter int OUT_SIZE = 1600,
	parameter int POS_W    = 13,
	parameter int IDX_W    = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               restart,
	input  logic [POS_W-1:0]   size,
	input  logic               push,
	input  logic signed [31:0] sample,
	input  logic               finite,
	input  logic               fifo_full,
	output logic               full,
	output logic               fifo_push,
	output aadw_pkg::item_t    fifo_item
);

	aadw_pkg::front_state_t state_q, state_nx;

	logic [POS_W-1:0] div_rem_q, q_q, r_q;
	logic [POS_W-1:0] col_q, row_q;
	logic [IDX_W-1:0] ocol_q, orow_q;
	logic [POS_W-1:0] col_start_q, col_end_q, col_rem_q;
	logic [POS_W-1:0] row_start_q, row_end_q, row_rem_q;

	logic             div_more;
	logic             acc;
	logic [POS_W-1:0] col_inc, row_inc;
	logic [POS_W:0]   col_sum, row_sum;
	logic             col_wrap, row_wrap;
	logic [POS_W-1:0] col_end_nx, col_rem_nx, row_end_nx, row_rem_nx;

	assign div_more = div_rem_q >= POS_W'(OUT_SIZE);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			aadw_pkg::F_INIT: state_nx = aadw_pkg::F_DIV;
			aadw_pkg::F_DIV:  if (!div_more) state_nx = aadw_pkg::F_RUN;
			aadw_pkg::F_RUN:  state_nx = aadw_pkg::F_RUN;
			default:          state_nx = aadw_pkg::F_INIT;
		endcase
		if (restart) state_nx = aadw_pkg::F_INIT;
	end

	always_comb begin
		full      = (state_q != aadw_pkg::F_RUN) || fifo_full;
		fifo_push = (state_q == aadw_pkg::F_RUN) && push && !fifo_full;
	end

	assign acc = fifo_push;

	// next bin edge: end += q, plus one when the fractional part carries
	assign col_sum    = {1'b0, col_rem_q} + {1'b0, r_q};
	assign col_wrap   = col_sum >= (POS_W+1)'(OUT_SIZE);
	assign col_end_nx = col_end_q + q_q + POS_W'(col_wrap);
	assign col_rem_nx = col_wrap ? POS_W'(col_sum - (POS_W+1)'(OUT_SIZE)) : POS_W'(col_sum);
	assign row_sum    = {1'b0, row_rem_q} + {1'b0, r_q};
	assign row_wrap   = row_sum >= (POS_W+1)'(OUT_SIZE);
	assign row_end_nx = row_end_q + q_q + POS_W'(row_wrap);
	assign row_rem_nx = row_wrap ? POS_W'(row_sum - (POS_W+1)'(OUT_SIZE)) : POS_W'(row_sum);

	assign col_inc = col_q + 1'b1;
	assign row_inc = row_q + 1'b1;

	always_comb begin
		fifo_item.sample     = sample;
		fifo_item.finite     = finite;
		fifo_item.first      = (col_q == col_start_q) && (row_q == row_start_q);
		fifo_item.last       = (col_inc == col_end_q) && (row_inc == row_end_q);
		fifo_item.frame_done = (ocol_q == IDX_W'(OUT_SIZE-1)) && (orow_q == IDX_W'(OUT_SIZE-1));
		fifo_item.col        = aadw_pkg::COORD_W'(ocol_q);
		fifo_item.row        = aadw_pkg::COORD_W'(orow_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aadw_pkg::F_INIT;
			div_rem_q   <= '0;
			q_q         <= '0;
			r_q         <= '0;
			col_q       <= '0;
			row_q       <= '0;
			ocol_q      <= '0;
			orow_q      <= '0;
			col_start_q <= '0;
			col_end_q   <= '0;
			col_rem_q   <= '0;
			row_start_q <= '0;
			row_end_q   <= '0;
			row_rem_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == aadw_pkg::F_INIT) begin
				div_rem_q <= size;
				q_q       <= '0;
			end else if (state_q == aadw_pkg::F_DIV) begin
				if (div_more) begin
					div_rem_q <= div_rem_q - POS_W'(OUT_SIZE);
					q_q       <= q_q + 1'b1;
				end else begin
					r_q         <= div_rem_q;
					col_q       <= '0;
					row_q       <= '0;
					ocol_q      <= '0;
					orow_q      <= '0;
					col_start_q <= '0;
					row_start_q <= '0;
					col_end_q   <= q_q;
					row_end_q   <= q_q;
					col_rem_q   <= div_rem_q;
					row_rem_q   <= div_rem_q;
				end
			end else if (acc) begin
				if (row_inc == size) begin
					row_q       <= '0;
					orow_q      <= '0;
					row_start_q <= '0;
					row_end_q   <= q_q;
					row_rem_q   <= r_q;
					if (col_inc == size) begin
						col_q       <= '0;
						ocol_q      <= '0;
						col_start_q <= '0;
						col_end_q   <= q_q;
						col_rem_q   <= r_q;
					end else begin
						col_q <= col_inc;
						if (col_inc == col_end_q) begin
							ocol_q      <= ocol_q + 1'b1;
							col_start_q <= col_end_q;
							col_end_q   <= col_end_nx;
							col_rem_q   <= col_rem_nx;
						end
					end
				end else begin
					row_q <= row_inc;
					if (row_inc == row_end_q) begin
						orow_q      <= orow_q + 1'b1;
						row_start_q <= row_end_q;
						row_end_q   <= row_end_nx;
						row_rem_q   <= row_rem_nx;
					end
				end
			end
		end
	end

endmodule

/* rtl/aadw_back.sv */
// Back section: per-row-bin accumulator memory, window mapping with a
// bit-serial divider, and the result register. Depends on aadw_pkg.
module aadw_back #(
	parameter int OUT_SIZE = 1600,
	parameter int IDX_W    = 11,
	parameter int CNT_W    = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fifo_empty,
	input  aadw_pkg::item_t              fifo_item,
	output logic                         fifo_pop,
	input  logic signed [31:0]           window_low,
	input  logic signed [31:0]           window_high,
	input  logic                         pop,
	output logic                         empty,
	output logic [aadw_pkg::GRAY_W-1:0]  gray,
	output logic [10:0]                  out_col,
	output logic [10:0]                  out_row,
	output logic                         frame_done
);

	localparam int SUM_W = 32 + CNT_W;
	localparam int DW    = 34 + CNT_W;
	localparam int SCL_W = 33 + CNT_W;
	localparam int DEN_W = 34 + CNT_W;
	localparam int NUM_W = 42 + CNT_W;
	localparam int MAX_CNT = (1 << CNT_W) - 1;

	aadw_pkg::back_state_t state_q, state_nx;

	logic [SUM_W+CNT_W-1:0] mem [OUT_SIZE];
	logic [SUM_W+CNT_W-1:0] rd_s1;
	aadw_pkg::item_t        item_s1;

	logic signed [SUM_W-1:0]  old_sum, new_sum, sum_q;
	logic [CNT_W-1:0]         old_cnt, new_cnt, cnt_q;
	logic signed [SUM_W-1:0]  smp_ext;

	logic signed [32+CNT_W:0] lowcnt_c;
	logic signed [DW-1:0]     d_c, d_q;
	logic [32:0]              span_c;
	logic [SCL_W-1:0]         scaled_c, scaled_q;
	logic                     zero_c;
	logic                     d_nonpos, d_sat;

	logic [NUM_W-1:0]         rem_q, den_sh;
	logic [DEN_W-1:0]         den_q;
	logic [2:0]               step_q;
	logic [aadw_pkg::GRAY_W-1:0] gray_q;
	logic                     div_ge;
	logic                     res_load;

	logic                     res_valid_q;
	logic [aadw_pkg::GRAY_W-1:0] res_gray_q;
	logic [10:0]              res_col_q, res_row_q;
	logic                     res_done_q;

	assign old_sum = rd_s1[SUM_W+CNT_W-1:CNT_W];
	assign old_cnt = rd_s1[CNT_W-1:0];
	assign smp_ext = SUM_W'(item_s1.sample);

	always_comb begin
		if (item_s1.first) begin
			new_sum = item_s1.finite ? smp_ext : '0;
			new_cnt = item_s1.finite ? CNT_W'(1) : '0;
		end else if (item_s1.finite) begin
			new_sum = old_sum + smp_ext;
			new_cnt = old_cnt + 1'b1;
		end else begin
			new_sum = old_sum;
			new_cnt = old_cnt;
		end
	end

	assign lowcnt_c = window_low * $signed({1'b0, cnt_q});
	assign d_c      = DW'(sum_q) - DW'(lowcnt_c);
	assign span_c   = 33'({window_high[31], window_high} - {window_low[31], window_low});
	assign scaled_c = SCL_W'(span_c) * SCL_W'(cnt_q);
	assign zero_c   = (cnt_q == '0) || !(window_high > window_low);

	assign d_nonpos = d_q <= 0;
	assign d_sat    = d_q >= $signed(DW'(scaled_q));

	assign den_sh = NUM_W'(den_q) << step_q;
	assign div_ge = rem_q >= den_sh;

	assign res_load = (state_q == aadw_pkg::B_OUT) && (!res_valid_q || pop);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			aadw_pkg::B_IDLE: if (!fifo_empty) state_nx = aadw_pkg::B_ACC;
			aadw_pkg::B_ACC:  state_nx = item_s1.last ? aadw_pkg::B_MUL : aadw_pkg::B_IDLE;
			aadw_pkg::B_MUL:  state_nx = zero_c ? aadw_pkg::B_OUT : aadw_pkg::B_CMP;
			aadw_pkg::B_CMP:  state_nx = (d_nonpos || d_sat) ? aadw_pkg::B_OUT : aadw_pkg::B_DIV;
			aadw_pkg::B_DIV:  if (step_q == '0) state_nx = aadw_pkg::B_OUT;
			aadw_pkg::B_OUT:  if (res_load) state_nx = aadw_pkg::B_IDLE;
			default:          state_nx = aadw_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		fifo_pop   = (state_q == aadw_pkg::B_IDLE) && !fifo_empty;
		empty      = !res_valid_q;
		gray       = res_gray_q;
		out_col    = res_col_q;
		out_row    = res_row_q;
		frame_done = res_done_q;
	end

	// accumulator store: read on dequeue, written back in the next cycle
	always_ff @(posedge clk) begin
		if (state_q == aadw_pkg::B_ACC) mem[item_s1.row[IDX_W-1:0]] <= {new_sum, new_cnt};
		if (fifo_pop) rd_s1 <= mem[fifo_item.row[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (fifo_pop) item_s1 <= fifo_item;
		if (state_q == aadw_pkg::B_ACC) begin
			sum_q <= new_sum;
			cnt_q <= new_cnt;
		end
		if (state_q == aadw_pkg::B_MUL) begin
			d_q      <= d_c;
			scaled_q <= scaled_c;
		end
		if (state_q == aadw_pkg::B_CMP) begin
			rem_q  <= NUM_W'($unsigned(d_q)) * NUM_W'(510) + NUM_W'(scaled_q);
			den_q  <= {scaled_q, 1'b0};
			step_q <= 3'd7;
		end else if (state_q == aadw_pkg::B_DIV) begin
			if (div_ge) rem_q <= rem_q - den_sh;
			step_q <= step_q - 1'b1;
		end
		if (res_load) begin
			res_gray_q <= gray_q;
			res_col_q  <= 11'(item_s1.col);
			res_row_q  <= 11'(item_s1.row);
			res_done_q <= item_s1.frame_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aadw_pkg::B_IDLE;
			res_valid_q <= 1'b0;
			gray_q      <= '0;
		end else begin
			state_q <= state_nx;
			if (res_load) res_valid_q <= 1'b1;
			else if (pop) res_valid_q <= 1'b0;
			unique case (state_q)
				aadw_pkg::B_MUL: gray_q <= '0;
				aadw_pkg::B_CMP: gray_q <= d_sat && !d_nonpos ? aadw_pkg::GRAY_MAX : '0;
				aadw_pkg::B_DIV: gray_q <= {gray_q[aadw_pkg::GRAY_W-2:0], div_ge};
				default:         gray_q <= gray_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_pop_to_acc: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_pop |=> state_q == aadw_pkg::B_ACC)
		else $error("dequeued item not accumulated next cycle");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == aadw_pkg::B_MUL |-> cnt_q <= CNT_W'(MAX_CNT))
		else $error("bin count out of range");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == aadw_pkg::B_DIV |-> den_q != '0)
		else $error("divider started with zero divisor");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == aadw_pkg::B_DIV |-> rem_q < (NUM_W'(den_q) << (4'(step_q) + 4'd1)))
		else $error("divider remainder escaped its bound");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !pop) |=> res_valid_q)
		else $error("result dropped before it was taken");
`endif

endmodule

/* rtl/area_average_downsample_window_level.sv */
// Path: the front tags each accepted item combinationally into the FIFO; the back
// dequeues it, reads its row bin's accumulator and writes the sum back; a bin's last
// item then runs the mapping, which may use the 8-step gray divider. The back takes
// no new item until the last is written back and, for a bin's last item, its result
// is loaded, which waits until the previous result is popped. Reset and any src_size
// write restart the frame; full stays high while the bin step is derived.
module area_average_downsample_window_level #(
	parameter int OUT_SIZE = 1600,
	parameter int MAX_SRC  = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] sample,
	input  logic               finite,
	output logic               empty,
	input  logic               pop,
	output logic [7:0]         gray,
	output logic [10:0]        out_col,
	output logic [10:0]        out_row,
	output logic               frame_done,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int SMAX  = (MAX_SRC > OUT_SIZE) ? MAX_SRC : OUT_SIZE;
	localparam int POS_W = $clog2(SMAX + 1);
	localparam int IDX_W = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;
	localparam int BIN_W = (SMAX + OUT_SIZE - 1) / OUT_SIZE;
	localparam int CNT_W = $clog2(BIN_W * BIN_W + 1);

	logic [12:0]        src_size_q;
	logic signed [31:0] window_low_q, window_high_q;
	logic               cfg_wr, restart;
	logic [31:0]        src_sat;
	logic [POS_W-1:0]   eff_size;

	logic               fifo_push, fifo_full, fifo_pop, fifo_empty;
	aadw_pkg::item_t    item_in, item_out;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign restart   = cfg_wr && (cfg_index == aadw_pkg::REG_SRC_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_size_q    <= 13'd3600;
			window_low_q  <= 32'sd0;
			window_high_q <= 32'sd128000;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				aadw_pkg::REG_SRC_SIZE: src_size_q    <= cfg_data[12:0];
				aadw_pkg::REG_WIN_LOW:  window_low_q  <= cfg_data;
				aadw_pkg::REG_WIN_HIGH: window_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign src_sat  = (32'(src_size_q) > 32'(MAX_SRC)) ? 32'(MAX_SRC) : 32'(src_size_q);
	assign eff_size = POS_W'((src_sat < 32'(OUT_SIZE)) ? 32'(OUT_SIZE) : src_sat);

	aadw_front #(
		.OUT_SIZE (OUT_SIZE),
		.POS_W    (POS_W),
		.IDX_W    (IDX_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.size      (eff_size),
		.push      (push),
		.sample    (sample),
		.finite    (finite),
		.fifo_full (fifo_full),
		.full      (full),
		.fifo_push (fifo_push),
		.fifo_item (item_in)
	);

	aadw_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fifo_push),
		.item_in  (item_in),
		.full     (fifo_full),
		.pop      (fifo_pop),
		.item_out (item_out),
		.empty    (fifo_empty)
	);

	aadw_back #(
		.OUT_SIZE (OUT_SIZE),
		.IDX_W    (IDX_W),
		.CNT_W    (CNT_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fifo_empty  (fifo_empty),
		.fifo_item   (item_out),
		.fifo_pop    (fifo_pop),
		.window_low  (window_low_q),
		.window_high (window_high_q),
		.pop         (pop),
		.empty       (empty),
		.gray        (gray),
		.out_col     (out_col),
		.out_row     (out_row),
		.frame_done  (frame_done)
	);

endmodule
